// File: sv/ffpa_pkg.sv
// Shared package of the first-fit partition allocator: field widths, mode and
// status codes, and the entry, carry and control structs used by the cell row.
// No dependencies.
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int MAX_PARTITIONS_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 8;
    localparam int SIZE_W   = 21;
    localparam int START_W  = 20;
    localparam int EIDX_W   = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;

    localparam logic [SIZE_W-1:0] MEM_MAX = SIZE_W'(1048576);

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADIDX   = 3'd5;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               used;
        logic [ID_W-1:0]    id;
    } ffpa_entry_t;

    // Scan token and what it has gathered so far, passed cell to cell.
    typedef struct packed {
        logic        token;
        logic        dup;
        logic        fit;
        logic        exact;
        logic        hit;
        ffpa_entry_t entry;
    } ffpa_carry_t;

    // What a cell shows its right-hand neighbor for the insert shift.
    typedef struct packed {
        ffpa_entry_t entry;
        logic        occ;
        logic        sel;
    } ffpa_nbr_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               init;
        logic [SIZE_W-1:0]  init_size;
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    part_id;
        logic [SIZE_W-1:0]  req_size;
        logic [EIDX_W-1:0]  entry_index;
        logic               commit;
        logic               split;
    } ffpa_ctl_t;

endpackage

// File: sv/ffpa_req_if.sv
// Request channel of the partition allocator: valid/ready plus request fields.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps

interface ffpa_req_if;
    import ffpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     part_id;
    logic [SIZE_W-1:0]   request_size;
    logic [EIDX_W-1:0]   entry_index;

    modport source (output valid, output mode, output part_id, output request_size,
                    output entry_index, input ready);
    modport sink   (input valid, input mode, input part_id, input request_size,
                    input entry_index, output ready);
endinterface

// File: sv/ffpa_rsp_if.sv
// Response channel of the partition allocator: valid/ready plus result fields.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps

interface ffpa_rsp_if;
    import ffpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  entry_start;
    logic [SIZE_W-1:0]   entry_size;
    logic                entry_used;
    logic [ID_W-1:0]     entry_id;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_start, output entry_size,
                    output entry_used, output entry_id, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_start, input entry_size,
                    input entry_used, input entry_id, input entry_count, output ready);
endinterface

// File: sv/first_fit_partition_allocator.sv
// Top level of the first-fit partition allocator: request sequencer and a row of
// MAX_PARTITIONS ffpa_cell instances. Depends on ffpa_pkg, ffpa_req_if, ffpa_rsp_if.
// Allocate, free and read send a scan token down the cell row one cell per cycle;
// clear and early rejects skip the scan. Results wait in S_DONE for the output
// register. One request at a time: a new one is taken only back in S_IDLE.
// Reset: memory size 1048576, one free partition over the whole memory, count 1.
`timescale 1ns / 1ps

module first_fit_partition_allocator #(
    parameter int MAX_PARTITIONS = ffpa_pkg::MAX_PARTITIONS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [ffpa_pkg::SIZE_W-1:0] cfg_write_data,
    ffpa_req_if.sink                    req,
    ffpa_rsp_if.source                  rsp
);
    import ffpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // sequencer state
    logic [1:0]          state_reg, state_next;
    logic [SIZE_W-1:0]   mem_size_reg, mem_size_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                launch_reg, launch_next;

    // latched request
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [EIDX_W-1:0]   index_reg, index_next;

    // finished result waiting for the output register
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    ffpa_entry_t         pend_entry_reg, pend_entry_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    ffpa_entry_t         out_entry_reg, out_entry_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    ffpa_ctl_t           ctl;
    ffpa_carry_t         carry [0:MAX_PARTITIONS];
    ffpa_nbr_t           nbr_out [0:MAX_PARTITIONS-1];
    ffpa_nbr_t           nbr_in [0:MAX_PARTITIONS-1];
    logic [MAX_PARTITIONS-1:0] occ_vec;

    logic                accept;
    logic                pre_reject;
    logic                scan_done;
    logic                table_full;
    logic [SIZE_W-1:0]   cfg_clamped;
    ffpa_carry_t         scan_end;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign scan_end   = carry[MAX_PARTITIONS];
    assign scan_done  = (state_reg == S_SCAN) && scan_end.token;
    assign table_full = (count_reg >= CNT_W'(MAX_PARTITIONS));

    // Zero or reserved id, empty or oversized size: answered without a scan.
    assign pre_reject = ((req.mode == MODE_ALLOC) &&
                         ((req.part_id == '0) || (req.request_size == '0) ||
                          (req.request_size > mem_size_reg))) ||
                        ((req.mode == MODE_FREE) && (req.part_id == '0));

    // Clamp the written memory size to the legal range.
    assign cfg_clamped = (cfg_write_data == '0)     ? SIZE_W'(1) :
                         (cfg_write_data > MEM_MAX) ? MEM_MAX : cfg_write_data;

    // Inject the scan token into the head cell; cells see no left neighbor there.
    assign carry[0] = {launch_reg, {($bits(ffpa_carry_t)-1){1'b0}}};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PARTITIONS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign nbr_in[gi] = '0;
            end
            else
            begin : g_body
                assign nbr_in[gi] = nbr_out[gi-1];
            end

            assign occ_vec[gi] = nbr_out[gi].occ;

            ffpa_cell #(
                .MAX_PARTITIONS (MAX_PARTITIONS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (IDX_W'(gi)),
                .ctl        (ctl),
                .carry_in   (carry[gi]),
                .carry_out  (carry[gi+1]),
                .nbr_in     (nbr_in[gi]),
                .nbr_out    (nbr_out[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        mem_size_next    = mem_size_reg;
        count_next       = count_reg;
        launch_next      = 1'b0;
        mode_next        = mode_reg;
        id_next          = id_reg;
        size_next        = size_reg;
        index_next       = index_reg;
        pend_status_next = pend_status_reg;
        pend_entry_next  = pend_entry_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_entry_next   = out_entry_reg;
        out_count_next   = out_count_reg;

        ctl.init        = 1'b0;
        ctl.init_size   = mem_size_reg;
        ctl.mode        = mode_reg;
        ctl.part_id     = id_reg;
        ctl.req_size    = size_reg;
        ctl.entry_index = index_reg;
        ctl.commit      = 1'b0;
        ctl.split       = 1'b0;

        // drop the response once taken
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // a register write restarts the table with the new size
        if (cfg_write_en)
        begin
            mem_size_next = cfg_clamped;
            count_next    = CNT_W'(1);
            ctl.init      = 1'b1;
            ctl.init_size = cfg_clamped;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = req.mode;
                    id_next         = req.part_id;
                    size_next       = req.request_size;
                    index_next      = req.entry_index;
                    pend_entry_next = '0;
                    state_next      = S_DONE;
                    if (req.mode == MODE_CLEAR)
                    begin
                        ctl.init         = 1'b1;
                        count_next       = CNT_W'(1);
                        pend_status_next = ST_OK;
                    end
                    else if (pre_reject)
                    begin
                        pend_status_next = ST_REJECT;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // token has left the last cell: settle the request
                if (scan_done)
                begin
                    state_next      = S_DONE;
                    pend_entry_next = '0;
                    case (mode_reg)
                        MODE_ALLOC:
                        begin
                            if (scan_end.dup)
                            begin
                                pend_status_next = ST_REJECT;
                            end
                            else if (!scan_end.fit)
                            begin
                                pend_status_next = ST_NOSPACE;
                            end
                            else if (!scan_end.exact && table_full)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                pend_status_next      = ST_OK;
                                ctl.commit            = 1'b1;
                                ctl.split             = !scan_end.exact;
                                pend_entry_next.start = scan_end.entry.start;
                                pend_entry_next.size  = size_reg;
                                pend_entry_next.used  = 1'b1;
                                pend_entry_next.id    = id_reg;
                                if (!scan_end.exact)
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        MODE_FREE:
                        begin
                            pend_status_next = scan_end.hit ? ST_OK : ST_NOTFOUND;
                        end
                        MODE_READ:
                        begin
                            if (scan_end.hit)
                            begin
                                pend_status_next = ST_OK;
                                pend_entry_next  = scan_end.entry;
                            end
                            else
                            begin
                                pend_status_next = ST_BADIDX;
                            end
                        end
                        default:
                        begin
                            pend_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_entry_next  = pend_entry_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mem_size_reg  <= MEM_MAX;
            count_reg     <= CNT_W'(1);
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mem_size_reg  <= mem_size_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        id_reg          <= id_next;
        size_reg        <= size_next;
        index_reg       <= index_next;
        pend_status_reg <= pend_status_next;
        pend_entry_reg  <= pend_entry_next;
        out_status_reg  <= out_status_next;
        out_entry_reg   <= out_entry_next;
        out_count_reg   <= out_count_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_start = out_entry_reg.start;
    assign rsp.entry_size  = out_entry_reg.size;
    assign rsp.entry_used  = out_entry_reg.used;
    assign rsp.entry_id    = out_entry_reg.id;
    assign rsp.entry_count = out_count_reg;

    // the number of occupied cells always equals the partition count
    a_count_matches_occ: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count_reg))
        else $error("partition count disagrees with occupied cells");

    a_split_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && ctl.split) |-> !table_full)
        else $error("split committed into a full table");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_end.token |-> (state_reg == S_SCAN))
        else $error("scan token left the row outside a scan");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted request did not start work");

endmodule

// File: sv/ffpa_cell.sv
// One partition-table cell: holds one entry, evaluates the passing scan token,
// and takes part in the insert shift. Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_cell #(
    parameter int MAX_PARTITIONS = ffpa_pkg::MAX_PARTITIONS_DEF,
    localparam int IDX_W = $clog2(MAX_PARTITIONS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      cell_index,
    input  ffpa_pkg::ffpa_ctl_t   ctl,
    input  ffpa_pkg::ffpa_carry_t carry_in,
    output ffpa_pkg::ffpa_carry_t carry_out,
    input  ffpa_pkg::ffpa_nbr_t   nbr_in,
    output ffpa_pkg::ffpa_nbr_t   nbr_out
);
    import ffpa_pkg::*;

    localparam int CMP_W = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;

    ffpa_entry_t entry_reg, entry_next;
    logic        occ_reg, occ_next;
    logic        sel_reg, sel_next;
    logic        after_reg, after_next;
    ffpa_carry_t carry_reg, carry_next;

    logic is_head;
    logic here_fits;
    logic id_match;
    logic idx_match;

    assign is_head   = (cell_index == '0);
    assign here_fits = occ_reg && !entry_reg.used && (entry_reg.size >= ctl.req_size);
    assign id_match  = occ_reg && (entry_reg.id == ctl.part_id);
    assign idx_match = occ_reg && (CMP_W'(cell_index) == CMP_W'(ctl.entry_index));

    always_comb
    begin
        carry_next = carry_in;
        entry_next = entry_reg;
        occ_next   = occ_reg;
        sel_next   = sel_reg;
        after_next = after_reg;

        if (carry_in.token)
        begin
            sel_next   = 1'b0;
            after_next = carry_in.fit;
            case (ctl.mode)
                MODE_ALLOC:
                begin
                    if (id_match)
                    begin
                        carry_next.dup = 1'b1;
                    end
                    if (!carry_in.fit && here_fits)
                    begin
                        carry_next.fit   = 1'b1;
                        carry_next.exact = (entry_reg.size == ctl.req_size);
                        carry_next.entry = entry_reg;
                        sel_next         = 1'b1;
                    end
                end
                MODE_FREE:
                begin
                    if (id_match)
                    begin
                        entry_next.used = 1'b0;
                        entry_next.id   = '0;
                        carry_next.hit  = 1'b1;
                    end
                end
                MODE_READ:
                begin
                    if (idx_match)
                    begin
                        carry_next.hit   = 1'b1;
                        carry_next.entry = entry_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.commit)
        begin
            if (sel_reg)
            begin
                entry_next.size = ctl.req_size;
                entry_next.used = 1'b1;
                entry_next.id   = ctl.part_id;
            end
            else if (ctl.split && after_reg)
            begin
                // shift right by one; the cell right of the fit takes the remainder
                if (nbr_in.sel)
                begin
                    entry_next.start = START_W'({1'b0, nbr_in.entry.start} + ctl.req_size);
                    entry_next.size  = nbr_in.entry.size - ctl.req_size;
                    entry_next.used  = 1'b0;
                    entry_next.id    = '0;
                end
                else
                begin
                    entry_next = nbr_in.entry;
                end
                occ_next = nbr_in.occ;
            end
        end

        if (ctl.init)
        begin
            entry_next      = '0;
            entry_next.size = is_head ? ctl.init_size : '0;
            occ_next        = is_head;
            sel_next        = 1'b0;
            after_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '{start: '0, size: (is_head ? MEM_MAX : '0), used: 1'b0, id: '0};
            occ_reg   <= is_head;
            sel_reg   <= 1'b0;
            after_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            occ_reg   <= occ_next;
            sel_reg   <= sel_next;
            after_reg <= after_next;
            carry_reg <= carry_next;
        end
    end

    assign carry_out     = carry_reg;
    assign nbr_out.entry = entry_reg;
    assign nbr_out.occ   = occ_reg;
    assign nbr_out.sel   = sel_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for first_fit_partition_allocator: directed table, then
// random allocate/free/read/clear traffic over several memory sizes, checked against
// typed rows or the bench predictor. Depends on ffpa_pkg, ffpa_req_if, ffpa_rsp_if.
`timescale 1ns / 1ps

module tb_top;
    import ffpa_pkg::*;

    localparam int MAX_PARTS       = 32;
    // Settle wait for wait_idle, sized from the row: the token walks one cell per cycle.
    localparam int LAT             = MAX_PARTS + 3;
    localparam int STALL_LIMIT     = 4000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int ID_POOL         = 40;
    localparam int NUM_DIR         = 22;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [EIDX_W-1:0] idx;
    } alloc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start;
        logic [SIZE_W-1:0]   size;
        logic                used;
        logic [ID_W-1:0]     id;
        logic [COUNT_W-1:0]  count;
    } alloc_rsp_t;

    typedef struct packed {
        alloc_req_t rq;
        logic       typed;
        alloc_rsp_t rsp;
    } dir_row_t;

    localparam alloc_rsp_t NO_RSP = '0;

    // Directed requests. Rows with typed = 1 carry their expected response; the
    // others are checked against the predictor. Runs from the reset state.
    localparam dir_row_t DIRECTED [NUM_DIR] = '{
        // read the single reset partition, then an index past the count
        '{'{MODE_READ, 8'd0, 21'd0, 5'd0}, 1'b1,
          '{ST_OK, 20'd0, 21'd1048576, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_READ, 8'd0, 21'd0, 5'd31}, 1'b1,
          '{ST_BADIDX, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        // reserved id, zero size, one past the memory, all-ones size
        '{'{MODE_ALLOC, 8'd0, 21'd16, 5'd0}, 1'b1,
          '{ST_REJECT, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_ALLOC, 8'd5, 21'd0, 5'd0}, 1'b1,
          '{ST_REJECT, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_ALLOC, 8'd5, 21'd1048577, 5'd0}, 1'b1,
          '{ST_REJECT, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_ALLOC, 8'd5, 21'h1FFFFF, 5'd0}, 1'b1,
          '{ST_REJECT, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        // exact fit of the whole memory with the top id
        '{'{MODE_ALLOC, 8'd255, 21'd1048576, 5'd0}, 1'b1,
          '{ST_OK, 20'd0, 21'd1048576, 1'b1, 8'd255, 6'd1}},
        // nothing free left; duplicate id
        '{'{MODE_ALLOC, 8'd7, 21'd1, 5'd0}, 1'b1,
          '{ST_NOSPACE, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_ALLOC, 8'd255, 21'd8, 5'd0}, 1'b1,
          '{ST_REJECT, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        // free: reserved id, unknown id, known id
        '{'{MODE_FREE, 8'd0, 21'd0, 5'd0}, 1'b1,
          '{ST_REJECT, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_FREE, 8'd9, 21'd0, 5'd0}, 1'b1,
          '{ST_NOTFOUND, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_FREE, 8'd255, 21'd0, 5'd0}, 1'b1,
          '{ST_OK, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_READ, 8'd0, 21'd0, 5'd0}, 1'b1,
          '{ST_OK, 20'd0, 21'd1048576, 1'b0, 8'd0, 6'd1}},
        // smallest request splits the partition
        '{'{MODE_ALLOC, 8'd1, 21'd1, 5'd0}, 1'b1,
          '{ST_OK, 20'd0, 21'd1, 1'b1, 8'd1, 6'd2}},
        '{'{MODE_READ, 8'd0, 21'd0, 5'd1}, 1'b0, NO_RSP},
        '{'{MODE_ALLOC, 8'd128, 21'd524287, 5'd0}, 1'b0, NO_RSP},
        '{'{MODE_ALLOC, 8'd2, 21'd1048575, 5'd0}, 1'b0, NO_RSP},
        '{'{MODE_FREE, 8'd1, 21'd0, 5'd0}, 1'b0, NO_RSP},
        // refill the freed one-byte hole exactly
        '{'{MODE_ALLOC, 8'd3, 21'd1, 5'd0}, 1'b0, NO_RSP},
        '{'{MODE_READ, 8'd0, 21'd0, 5'd2}, 1'b0, NO_RSP},
        '{'{MODE_CLEAR, 8'd0, 21'd0, 5'd0}, 1'b1,
          '{ST_OK, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}},
        '{'{MODE_READ, 8'd0, 21'd0, 5'd1}, 1'b1,
          '{ST_BADIDX, 20'd0, 21'd0, 1'b0, 8'd0, 6'd1}}
    };

    // Memory size per phase; 0 and all-ones exercise the clamp, the last is random.
    localparam logic [SIZE_W-1:0] PHASE_MEM [NUM_PHASES] = '{
        21'd1048576, 21'd64, 21'd1, 21'd0, 21'd4096, 21'h1FFFFF, 21'd1000, 21'd0
    };
    localparam int FILL_PHASE  = 4;
    localparam int QUIET_PHASE = 1;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write_en;
    logic [SIZE_W-1:0]   cfg_write_data;

    ffpa_req_if req_ch ();
    ffpa_rsp_if rsp_ch ();

    first_fit_partition_allocator #(
        .MAX_PARTITIONS (MAX_PARTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch)
    );

    always #2 clk = ~clk;

    // Predictor state: partition table, entry count and managed memory size.
    ffpa_entry_t part_tbl [MAX_PARTS];
    int          part_cnt;
    int          mem_bytes;
    int          peak_cnt;

    alloc_rsp_t  expected_rsps [$];
    alloc_rsp_t  want_rsp;
    int          errors;
    int          sent;
    int          checked;
    int          st_seen [6];
    int          stall_cycles;
    bit          quiet;

    // Restore one free partition over the whole memory.
    function automatic void reset_table();
        for (int i = 0; i < MAX_PARTS; i++)
            part_tbl[i] = '0;
        part_tbl[0].size = SIZE_W'(mem_bytes);
        part_cnt = 1;
    endfunction

    // Apply one request to the predicted table and return its response.
    function automatic alloc_rsp_t predict(input alloc_req_t rq);
        alloc_rsp_t          o;
        int                  req;
        int                  slot;
        logic [STATUS_W-1:0] st;
        bit                  hit;

        o    = '0;
        slot = -1;
        req  = int'(rq.size);
        st   = ST_OK;
        case (rq.mode)
            MODE_ALLOC:
            begin
                if (rq.id == '0 || req == 0 || req > mem_bytes)
                    st = ST_REJECT;
                else
                begin
                    for (int i = 0; i < part_cnt; i++)
                        if (part_tbl[i].id == rq.id)
                            st = ST_REJECT;
                end
                if (st == ST_OK)
                begin
                    // first fit: lowest free partition that holds the request
                    for (int i = part_cnt - 1; i >= 0; i--)
                        if (!part_tbl[i].used && int'(part_tbl[i].size) >= req)
                            slot = i;
                    if (slot < 0)
                        st = ST_NOSPACE;
                    else if (int'(part_tbl[slot].size) > req && part_cnt >= MAX_PARTS)
                        st = ST_FULL;
                    else
                    begin
                        if (int'(part_tbl[slot].size) > req)
                        begin
                            // shift up and insert the free remainder after the slot
                            for (int k = part_cnt; k > slot + 1; k--)
                                part_tbl[k] = part_tbl[k - 1];
                            part_tbl[slot + 1].start =
                                START_W'(int'(part_tbl[slot].start) + req);
                            part_tbl[slot + 1].size =
                                SIZE_W'(int'(part_tbl[slot].size) - req);
                            part_tbl[slot + 1].used = 1'b0;
                            part_tbl[slot + 1].id   = '0;
                            part_cnt++;
                        end
                        part_tbl[slot].size = SIZE_W'(req);
                        part_tbl[slot].used = 1'b1;
                        part_tbl[slot].id   = rq.id;
                        o.start = part_tbl[slot].start;
                        o.size  = part_tbl[slot].size;
                        o.used  = 1'b1;
                        o.id    = rq.id;
                    end
                end
            end
            MODE_FREE:
            begin
                hit = 1'b0;
                if (rq.id == '0)
                    st = ST_REJECT;
                else
                begin
                    // no merging of neighbors on free
                    for (int i = 0; i < part_cnt; i++)
                        if (part_tbl[i].id == rq.id)
                        begin
                            part_tbl[i].used = 1'b0;
                            part_tbl[i].id   = '0;
                            hit = 1'b1;
                        end
                    st = hit ? ST_OK : ST_NOTFOUND;
                end
            end
            MODE_READ:
            begin
                if (int'(rq.idx) < part_cnt)
                begin
                    o.start = part_tbl[rq.idx].start;
                    o.size  = part_tbl[rq.idx].size;
                    o.used  = part_tbl[rq.idx].used;
                    o.id    = part_tbl[rq.idx].id;
                end
                else
                    st = ST_BADIDX;
            end
            default:
                reset_table();
        endcase
        o.status = st;
        o.count  = COUNT_W'(part_cnt);
        if (part_cnt > peak_cnt)
            peak_cnt = part_cnt;
        return o;
    endfunction

    // Draw one random request shaped by the current predicted table.
    function automatic alloc_req_t gen_request();
        alloc_req_t rq;
        int         r;
        int         hi;

        r = $urandom_range(0, 99);
        if (r < 4)
            rq.id = '0;
        else if (r < 10)
            rq.id = ID_W'($urandom_range(0, 255));
        else
            rq.id = ID_W'($urandom_range(1, ID_POOL));

        hi = mem_bytes / 16;
        if (hi < 1)
            hi = 1;
        r = $urandom_range(0, 99);
        if (r < 60)
            rq.size = SIZE_W'($urandom_range(1, hi));
        else if (r < 75)
            rq.size = SIZE_W'($urandom_range(1, mem_bytes));
        else if (r < 88)
            rq.size = part_tbl[$urandom_range(0, part_cnt - 1)].size;
        else if (r < 94)
            rq.size = '0;
        else
            rq.size = SIZE_W'($urandom_range(mem_bytes + 1, 2097151));

        if ($urandom_range(0, 99) < 75)
            rq.idx = EIDX_W'($urandom_range(0, part_cnt - 1));
        else
            rq.idx = EIDX_W'($urandom_range(0, 31));

        r = $urandom_range(0, 99);
        if (r < 55)
            rq.mode = MODE_ALLOC;
        else if (r < 75)
            rq.mode = MODE_FREE;
        else if (r < 97)
            rq.mode = MODE_READ;
        else
            rq.mode = MODE_CLEAR;
        return rq;
    endfunction

    // Drive one request from the falling edge, hold it until accepted, then
    // queue its expected response.
    task automatic issue(input alloc_req_t rq, input logic typed, input alloc_rsp_t typed_rsp);
        alloc_rsp_t want;

        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 16)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= rq.mode;
        req_ch.part_id      <= rq.id;
        req_ch.request_size <= rq.size;
        req_ch.entry_index  <= rq.idx;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        want = predict(rq);
        if (typed)
            want = typed_rsp;
        expected_rsps.push_back(want);
        sent++;
    endtask

    // Drop valid, wait for every pending response, then let the scan settle.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);
    endtask

    // Write memory_size while idle; mirror the clamp and table re-init.
    task automatic write_mem_size(input logic [SIZE_W-1:0] val);
        int v;

        wait_idle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= val;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        v = int'(val);
        if (v == 0)
            v = 1;
        if (v > int'(MEM_MAX))
            v = int'(MEM_MAX);
        mem_bytes = v;
        reset_table();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Response side: stall ready at random unless in the quiet stretch.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= rst_n && (quiet || $urandom_range(0, 99) >= 16);
        end
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response with nothing pending: status %0d", rsp_ch.status);
                errors++;
            end
            else
            begin
                want_rsp = expected_rsps.pop_front();
                check_field("status", want_rsp.status, rsp_ch.status);
                check_field("entry_start", want_rsp.start, rsp_ch.entry_start);
                check_field("entry_size", want_rsp.size, rsp_ch.entry_size);
                check_field("entry_used", want_rsp.used, rsp_ch.entry_used);
                check_field("entry_id", want_rsp.id, rsp_ch.entry_id);
                check_field("entry_count", want_rsp.count, rsp_ch.entry_count);
                if (int'(want_rsp.status) < 6)
                    st_seen[want_rsp.status]++;
                checked++;
            end
        end
    end

    // Count cycles in which neither channel moves a request or response.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("timeout: no handshake for %0d cycles, %0d responses pending",
                 STALL_LIMIT, expected_rsps.size());
        $display("first_fit_partition_allocator regression: fail");
        $finish;
    end

    initial
    begin
        logic [SIZE_W-1:0] val;

        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = '0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_READ;
        req_ch.part_id      = '0;
        req_ch.request_size = '0;
        req_ch.entry_index  = '0;
        quiet               = 1'b0;
        errors              = 0;
        sent                = 0;
        checked             = 0;
        peak_cnt            = 0;
        for (int i = 0; i < 6; i++)
            st_seen[i] = 0;
        mem_bytes = int'(MEM_MAX);
        reset_table();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, from the reset state.
        for (int i = 0; i < NUM_DIR; i++)
            issue(DIRECTED[i].rq, DIRECTED[i].typed, DIRECTED[i].rsp);

        // Random part: one memory size per phase.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            val = PHASE_MEM[p];
            if (p == NUM_PHASES - 1)
                val = SIZE_W'($urandom_range(1, 1048576));
            write_mem_size(val);
            quiet = (p == QUIET_PHASE);
            if (p == FILL_PHASE)
            begin
                // Fill the table with small splits so the last one hits table full.
                for (int i = 1; i <= MAX_PARTS; i++)
                    issue('{MODE_ALLOC, ID_W'(i), SIZE_W'($urandom_range(1, 8)), 5'd0},
                          1'b0, NO_RSP);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Hold off mid-phase until every pending response is back.
                if (n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                issue(gen_request(), 1'b0, NO_RSP);
            end
        end
        quiet = 1'b0;

        wait_idle();
        repeat (LAT) @(posedge clk);

        $display("ran %0d requests, checked %0d responses over %0d memory sizes, peak %0d entries",
                 sent, checked, NUM_PHASES + 1, peak_cnt);
        $display("ok %0d, no space %0d, rejected %0d, not found %0d, full %0d, bad index %0d",
                 st_seen[ST_OK], st_seen[ST_NOSPACE], st_seen[ST_REJECT],
                 st_seen[ST_NOTFOUND], st_seen[ST_FULL], st_seen[ST_BADIDX]);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("first_fit_partition_allocator regression: pass");
        else
            $display("first_fit_partition_allocator regression: fail");
        $finish;
    end

endmodule
